// ----- hw/rtl/cmdtok_pkg.sv -----
`timescale 1ns / 1ps

package cmdtok_pkg;

  // Argument count saturation point and the largest value the count field holds
  localparam int MAX_ARGS    = 64;
  localparam int ARG_LIMIT   = 127;
  // Bundles held between the classifier and the result serializer
  localparam int QUEUE_DEPTH = 4;
  // Most results one input item can cause
  localparam int MAX_RESULTS = 4;

  // Result kinds
  typedef enum logic [1:0] {
    KIND_BYTE    = 2'd0,
    KIND_TERM    = 2'd1,
    KIND_SUMMARY = 2'd2
  } kind_e;

  // Parse mode bits
  localparam logic [4:0] MODE_NONE    = 5'd0;
  localparam logic [4:0] MODE_INARG   = 5'd2;
  localparam logic [4:0] MODE_SQ      = 5'd4;
  localparam logic [4:0] MODE_DQ      = 5'd8;
  localparam logic [4:0] MODE_SPECIAL = 5'd16;

  // Flag bit positions
  localparam int FLAG_PIPE  = 0;
  localparam int FLAG_JOB   = 1;
  localparam int FLAG_BQ    = 2;
  localparam int FLAG_PAREN = 3;
  localparam int FLAG_WILD  = 4;
  localparam int FLAG_USQ   = 5;
  localparam int FLAG_UDQ   = 6;
  localparam int FLAG_OVF   = 7;

  // Characters with a meaning of their own
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_PIPE   = 8'h7C;
  localparam logic [7:0] CH_BQUOTE = 8'h60;
  localparam logic [7:0] CH_LPAREN = 8'h28;
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_QMARK  = 8'h3F;
  localparam logic [7:0] CH_AMP    = 8'h26;
  localparam logic [7:0] CH_SEMI   = 8'h3B;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       byte_valid;
    logic       is_last;
  } tok_in_t;

  typedef struct packed {
    kind_e      kind;
    logic [7:0] out_byte;
    logic       starts_arg;
    logic [6:0] arg_count;
    logic [7:0] flag_bits;
    logic       done_res;
  } tok_out_t;

  // All results of one input item, slot 0 first
  typedef struct packed {
    tok_out_t [MAX_RESULTS-1:0] slot;
    logic [1:0]                 last_idx;
  } tok_bundle_t;

  // Handshake between the queue and the serializer
  typedef struct packed {
    logic        empty;
    tok_bundle_t head;
  } tok_qhead_t;

endpackage

// ----- hw/rtl/command_line_tokenizer.sv -----
`timescale 1ns / 1ps

// Shell-style command line tokenizer. Feed the string one byte per transfer on
// the input channel, with is_last on the final transfer (an end marker with
// byte_valid low closes an empty string). The block returns argument bytes,
// argument terminators and one end summary per string, each as a separate
// output transfer, in string order. A byte is accepted every cycle while the
// bundle queue has room (in_stall_o is the queue-full flag); each accepted item
// yields zero to four results, and results leave at one per cycle while
// out_stall_i is low, so the sustained input rate is one item per cycle when
// items average one result or less, and otherwise is set by the single output
// port. With the queue empty, the first result of an item goes through the queue
// and then the output register: the classifier writes the queue on the transfer
// and the output register loads from the queue head. The queue holds QueueDepth
// items' worth of results to ride out output stalls and bursts.
module command_line_tokenizer import cmdtok_pkg::*; #(
  parameter int MaxArgs    = MAX_ARGS,
  parameter int QueueDepth = QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  tok_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output tok_out_t out_data_o
);

  localparam logic [6:0] ArgCap = (MaxArgs > ARG_LIMIT) ? 7'(ARG_LIMIT) : 7'(MaxArgs);

  logic        accept;
  logic        push;
  logic        full;
  logic        pop;
  tok_bundle_t bundle;
  tok_qhead_t  qhead;

  // Take a transfer whenever the queue can hold its results
  assign in_stall_o = full;
  assign accept     = in_valid_i && !full;

  // Front: parse state and classification of each byte into its results
  cmdtok_front #(
    .MaxArgs (MaxArgs)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .accept_i  (accept),
    .in_data_i (in_data_i),
    .push_o    (push),
    .bundle_o  (bundle)
  );

  // Queue: decouple classification from result delivery
  cmdtok_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (bundle),
    .full_o (full),
    .pop_i  (pop),
    .head_o (qhead)
  );

  // Back: hand out the queued results one transfer at a time
  cmdtok_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .qhead_i     (qhead),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

`ifndef SYNTHESIS
  // Summary and done marker always travel together
  a_done_is_summary: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.done_res == (out_data_o.kind == KIND_SUMMARY)))
    else $error("done_res and summary kind disagree");

  // A summary never marks an argument start
  a_summary_no_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.done_res) |-> !out_data_o.starts_arg)
    else $error("summary carries starts_arg");

  // Count saturates at the cap
  a_count_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.arg_count <= ArgCap))
    else $error("argument count above cap");

  // A closing item always leaves results queued
  a_last_pushes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && in_data_i.is_last) |=> !qhead.empty)
    else $error("end of string produced no results");
`endif

endmodule

// ----- hw/rtl/cmdtok_front.sv -----
`timescale 1ns / 1ps

module cmdtok_front import cmdtok_pkg::*; #(
  parameter int MaxArgs = MAX_ARGS
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        accept_i,
  input  tok_in_t     in_data_i,
  output logic        push_o,
  output tok_bundle_t bundle_o
);

  localparam logic [6:0] ArgCap = (MaxArgs > ARG_LIMIT) ? 7'(ARG_LIMIT) : 7'(MaxArgs);

  logic [4:0] mode_q, mode_d;
  logic       esc_q, esc_d;
  logic [7:0] prev_q, prev_d;
  logic       seen_q, seen_d;
  logic [6:0] total_q, total_d;
  logic [7:0] flags_q, flags_d;
  logic       start_q, start_d;

  logic       in_quote;
  logic       copy_v;
  logic [4:0] mine_v, other_v;
  logic [2:0] n_v;
  logic [7:0] sum_flags;
  tok_out_t [MAX_RESULTS-1:0] slots_v;

  function automatic tok_out_t make_res(kind_e k, logic [7:0] b, logic s,
                                        logic [6:0] cnt, logic [7:0] f, logic d);
    tok_out_t r;
    r.kind       = k;
    r.out_byte   = b;
    r.starts_arg = s;
    r.arg_count  = cnt;
    r.flag_bits  = f;
    r.done_res   = d;
    return r;
  endfunction

  assign in_quote = ((mode_q & (MODE_SQ | MODE_DQ)) != 5'd0);

  always_comb begin
    mode_d    = mode_q;
    esc_d     = esc_q;
    prev_d    = prev_q;
    seen_d    = seen_q;
    total_d   = total_q;
    flags_d   = flags_q;
    start_d   = start_q;
    slots_v   = '0;
    n_v       = 3'd0;
    copy_v    = 1'b0;
    mine_v    = MODE_SQ;
    other_v   = MODE_DQ;
    sum_flags = 8'd0;

    if (accept_i && in_data_i.byte_valid) begin
      if (esc_d) begin
        esc_d  = 1'b0;
        copy_v = 1'b1;
      end else begin
        case (in_data_i.in_byte)
          CH_SPACE, CH_TAB, CH_CR, CH_LF: begin
            if (mode_d == MODE_INARG) begin
              mode_d = MODE_NONE;
              slots_v[n_v[1:0]] = make_res(KIND_TERM, 8'd0, start_d, total_d, flags_d, 1'b0);
              n_v     = n_v + 3'd1;
              start_d = 1'b0;
            end else if (in_quote) begin
              copy_v = 1'b1;
            end
          end
          CH_BSLASH: begin
            esc_d = 1'b1;
          end
          CH_SQUOTE, CH_DQUOTE: begin
            if (in_data_i.in_byte == CH_DQUOTE) begin
              mine_v  = MODE_DQ;
              other_v = MODE_SQ;
            end
            if ((mode_d & other_v) != 5'd0) begin
              copy_v = 1'b1;
            end else if ((mode_d & mine_v) != 5'd0) begin
              mode_d = mode_d & ~mine_v;
            end else if (mode_d == MODE_NONE || mode_d == MODE_INARG) begin
              // Opening quote on a fresh argument starts it now
              if (mode_d == MODE_NONE) begin
                if (total_d < ArgCap) total_d = total_d + 7'd1;
                else flags_d[FLAG_OVF] = 1'b1;
                start_d = 1'b1;
              end
              mode_d = mine_v | MODE_INARG;
            end else begin
              copy_v = 1'b1;
            end
          end
          CH_PIPE: begin
            if (!in_quote) flags_d[FLAG_PIPE] = 1'b1;
            copy_v = 1'b1;
          end
          CH_BQUOTE: begin
            if (!in_quote) flags_d[FLAG_BQ] = 1'b1;
            copy_v = 1'b1;
          end
          CH_LPAREN: begin
            if (!in_quote) flags_d[FLAG_PAREN] = 1'b1;
            copy_v = 1'b1;
          end
          CH_STAR, CH_QMARK: begin
            if (!in_quote) flags_d[FLAG_WILD] = 1'b1;
            copy_v = 1'b1;
          end
          CH_AMP, CH_SEMI: begin
            if (!in_quote) begin
              mode_d = MODE_SPECIAL;
              flags_d[FLAG_JOB] = 1'b1;
              // Split off a new argument unless this is the first byte or repeats the byte before
              if (seen_q && prev_q != in_data_i.in_byte) begin
                slots_v[n_v[1:0]] = make_res(KIND_TERM, 8'd0, start_d, total_d, flags_d, 1'b0);
                n_v     = n_v + 3'd1;
                if (total_d < ArgCap) total_d = total_d + 7'd1;
                else flags_d[FLAG_OVF] = 1'b1;
                start_d = 1'b1;
              end
            end
            copy_v = 1'b1;
          end
          default: begin
            copy_v = 1'b1;
          end
        endcase
      end

      if (copy_v) begin
        if (mode_d == MODE_NONE) begin
          mode_d = MODE_INARG;
          if (total_d < ArgCap) total_d = total_d + 7'd1;
          else flags_d[FLAG_OVF] = 1'b1;
          start_d = 1'b1;
        end
        slots_v[n_v[1:0]] = make_res(KIND_BYTE, in_data_i.in_byte, start_d, total_d,
                                     flags_d, 1'b0);
        n_v     = n_v + 3'd1;
        start_d = 1'b0;
      end
      prev_d = in_data_i.in_byte;
      seen_d = 1'b1;
    end

    if (accept_i && in_data_i.is_last) begin
      // Dangling backslash stands for a zero byte
      if (esc_d) begin
        esc_d = 1'b0;
        if (mode_d == MODE_NONE) begin
          mode_d = MODE_INARG;
          if (total_d < ArgCap) total_d = total_d + 7'd1;
          else flags_d[FLAG_OVF] = 1'b1;
          start_d = 1'b1;
        end
        slots_v[n_v[1:0]] = make_res(KIND_BYTE, 8'd0, start_d, total_d, flags_d, 1'b0);
        n_v     = n_v + 3'd1;
        start_d = 1'b0;
      end
      slots_v[n_v[1:0]] = make_res(KIND_TERM, 8'd0, start_d, total_d, flags_d, 1'b0);
      n_v = n_v + 3'd1;
      sum_flags = flags_d;
      sum_flags[FLAG_USQ] = ((mode_d & MODE_SQ) != 5'd0);
      sum_flags[FLAG_UDQ] = ((mode_d & MODE_DQ) != 5'd0);
      slots_v[n_v[1:0]] = make_res(KIND_SUMMARY, 8'd0, 1'b0, total_d, sum_flags, 1'b1);
      n_v = n_v + 3'd1;
      // Start the next string from a clean state
      mode_d  = MODE_NONE;
      esc_d   = 1'b0;
      prev_d  = 8'd0;
      seen_d  = 1'b0;
      total_d = 7'd0;
      flags_d = 8'd0;
      start_d = 1'b0;
    end
  end

  assign push_o            = (n_v != 3'd0);
  assign bundle_o.slot     = slots_v;
  assign bundle_o.last_idx = 2'(n_v - 3'd1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_NONE;
      esc_q   <= 1'b0;
      prev_q  <= 8'd0;
      seen_q  <= 1'b0;
      total_q <= 7'd0;
      flags_q <= 8'd0;
      start_q <= 1'b0;
    end else begin
      mode_q  <= mode_d;
      esc_q   <= esc_d;
      prev_q  <= prev_d;
      seen_q  <= seen_d;
      total_q <= total_d;
      flags_q <= flags_d;
      start_q <= start_d;
    end
  end

endmodule

// ----- hw/rtl/cmdtok_queue.sv -----
`timescale 1ns / 1ps

module cmdtok_queue import cmdtok_pkg::*; #(
  parameter int Depth = QUEUE_DEPTH
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  tok_bundle_t data_i,
  output logic        full_o,
  input  logic        pop_i,
  output tok_qhead_t  head_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);

  tok_bundle_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [AddrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic             do_push, do_pop;

  assign full_o      = (cnt_q == CntW'(Depth));
  assign head_o.empty = (cnt_q == '0);
  assign head_o.head  = mem_q[rd_ptr_q];

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !head_o.empty;

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_push) begin
      wr_ptr_d = (wr_ptr_q == AddrW'(Depth - 1)) ? '0 : wr_ptr_q + AddrW'(1);
    end
    if (do_pop) begin
      rd_ptr_d = (rd_ptr_q == AddrW'(Depth - 1)) ? '0 : rd_ptr_q + AddrW'(1);
    end
    if (do_push && !do_pop) cnt_d = cnt_q + CntW'(1);
    else if (do_pop && !do_push) cnt_d = cnt_q - CntW'(1);
  end

  always_ff @(posedge clk_i) begin
    if (do_push) mem_q[wr_ptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- hw/rtl/cmdtok_back.sv -----
`timescale 1ns / 1ps

module cmdtok_back import cmdtok_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  tok_qhead_t qhead_i,
  output logic       pop_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output tok_out_t   out_data_o
);

  logic [1:0] idx_q, idx_d;
  logic       out_valid_q, out_valid_d;
  tok_out_t   out_data_q;
  logic       load;

  // Output slot takes a new result when empty or being drained this cycle
  assign load = !qhead_i.empty && (!out_valid_q || !out_stall_i);

  always_comb begin
    idx_d       = idx_q;
    out_valid_d = out_valid_q;
    pop_o       = 1'b0;
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (load) begin
      out_valid_d = 1'b1;
      if (idx_q == qhead_i.head.last_idx) begin
        pop_o = 1'b1;
        idx_d = 2'd0;
      end else begin
        idx_d = idx_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) out_data_q <= qhead_i.head.slot[idx_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q       <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      idx_q       <= idx_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule
